/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by hll_wave_speed_wet_dry.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, quiet while rst_n is low.
`define HWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression never holds on a rising edge of clk.
`define HWS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* design/hws_pkg.sv */
// ----------------------------------------------------------------------------
// hws_pkg
// Widths, constants, face case codes, the square root step and the saturation
// function for the HLL wave speed pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hws_pkg;

  localparam int VEL_W   = 32;
  localparam int DEPTH_W = 31;
  localparam int FACE_W  = 2;
  localparam int GRAV_W  = 20;
  localparam int PROD_W  = DEPTH_W + GRAV_W;   // g * depth, Q19.32
  localparam int RAD_W   = PROD_W + 1;         // padded to an even width
  localparam int ROOT_W  = RAD_W / 2;          // one root bit per stage
  localparam int REM_W   = ROOT_W + 1;         // remainder never exceeds 2*root
  localparam int CUR_W   = REM_W + 2;
  localparam int WIDE_W  = 36;                 // exact intermediate width

  // round(9.81 * 65536)
  localparam logic [GRAV_W-1:0] GRAV_Q16 = 20'd642908;

  localparam logic signed [FACE_W-1:0] FACE_WET = 2'sb01;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [VEL_W-1:0]  vel_t;

  typedef enum logic [2:0] {
    FC_NONE,
    FC_BOTH_WET,
    FC_LEFT_DRY,
    FC_RIGHT_DRY,
    FC_BOTH_DRY
  } face_case_t;

  // One lane of the square root pipeline
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sq_t;

  // Retire one root bit: bring down two radicand bits, try the subtraction.
  function automatic sq_t sq_step(sq_t s);
    logic [CUR_W-1:0] cur;
    logic [CUR_W-1:0] trial;
    logic [CUR_W-1:0] diff;
    logic             ge;
    sq_t              n;
    cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    diff  = cur - trial;
    ge    = (cur >= trial);
    n.rad  = {s.rad[RAD_W-3:0], 2'b00};
    n.root = {s.root[ROOT_W-2:0], ge};
    n.rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    return n;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic vel_t sat_vel(wide_t x);
    wide_t hi;
    wide_t lo;
    vel_t  r;
    hi = {{(WIDE_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
    lo = {{(WIDE_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};
    if (x > hi) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else if (x < lo) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = x[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/hll_wave_speed_wet_dry.sv */
// ----------------------------------------------------------------------------
// hll_wave_speed_wet_dry
// HLL left, right and star wave speeds for one shallow-water cell face, with
// wet/dry handling, on a fully pipelined Q16.16 datapath.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                               Moves
//  -------   ---------------------------------   ----------------------------
//  input     in_valid / in_stall  + in_* fields  one face per transfer
//  result    out_valid / out_stall + out_*       one speed set per face
//
//  One face enters per cycle while no result is stalled; results leave in order.
//  The depth is set by the square root: one stage per root bit (26 stages)
//  for both celerities side by side, after one multiplier stage and before
//  four stages of adds, min/max selection and saturation.
//  rst_n (synchronous) clears only the valid bits; payload is not reset.
//  A stalled result freezes the whole pipeline, so in_stall follows
//  out_stall while a result is on show; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hll_wave_speed_wet_dry (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [hws_pkg::VEL_W-1:0]      in_vel_left,
  input  logic signed [hws_pkg::VEL_W-1:0]      in_vel_right,
  input  logic        [hws_pkg::DEPTH_W-1:0]    in_depth_left,
  input  logic        [hws_pkg::DEPTH_W-1:0]    in_depth_right,
  input  logic                                  in_wet_left,
  input  logic                                  in_wet_right,
  input  logic signed [hws_pkg::FACE_W-1:0]     in_face_state_left,
  input  logic signed [hws_pkg::FACE_W-1:0]     in_face_state_right,
  input  logic                                  in_cell_active,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [hws_pkg::VEL_W-1:0]      out_speed_left,
  output logic signed [hws_pkg::VEL_W-1:0]      out_speed_right,
  output logic signed [hws_pkg::VEL_W-1:0]      out_speed_star,
  output logic                                  out_updated
);

  localparam int NSQ = hws_pkg::ROOT_W;

  // Whole-pipeline advance: hold everything while a result waits
  logic out_valid_r;
  logic adv;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Stage 0: decode the face case, form g * depth on both sides
  // --------------------------------------------------------------------------
  hws_pkg::face_case_t fc_nxt;
  logic                fl_wet;
  logic                fr_wet;
  logic                fl_dry;
  logic                fr_dry;

  assign fl_wet = (in_face_state_left  == hws_pkg::FACE_WET);
  assign fr_wet = (in_face_state_right == hws_pkg::FACE_WET);
  assign fl_dry = in_face_state_left[hws_pkg::FACE_W-1];
  assign fr_dry = in_face_state_right[hws_pkg::FACE_W-1];

  // Order matters: the first matching case wins
  always_comb begin
    priority if (!in_cell_active) begin
      fc_nxt = hws_pkg::FC_NONE;
    end else if (in_wet_left && in_wet_right && fl_wet && fr_wet) begin
      fc_nxt = hws_pkg::FC_BOTH_WET;
    end else if ((!in_wet_left && in_wet_right) || (fl_dry && fr_wet)) begin
      fc_nxt = hws_pkg::FC_LEFT_DRY;
    end else if ((in_wet_left && !in_wet_right) || (fl_wet && fr_dry)) begin
      fc_nxt = hws_pkg::FC_RIGHT_DRY;
    end else if ((!in_wet_left && !in_wet_right) || (fl_dry && fr_dry)) begin
      fc_nxt = hws_pkg::FC_BOTH_DRY;
    end else begin
      fc_nxt = hws_pkg::FC_NONE;
    end
  end

  logic [hws_pkg::PROD_W-1:0] prod_l_nxt;
  logic [hws_pkg::PROD_W-1:0] prod_r_nxt;

  assign prod_l_nxt = hws_pkg::PROD_W'(in_depth_left)  * hws_pkg::PROD_W'(hws_pkg::GRAV_Q16);
  assign prod_r_nxt = hws_pkg::PROD_W'(in_depth_right) * hws_pkg::PROD_W'(hws_pkg::GRAV_Q16);

  // --------------------------------------------------------------------------
  // Square root pipeline: entry 0 is the multiplier register, entry k holds
  // k root bits. Velocities and case code ride alongside.
  // --------------------------------------------------------------------------
  logic [NSQ:0]        sq_vld_r;
  hws_pkg::sq_t        sq_l_r   [NSQ+1];
  hws_pkg::sq_t        sq_r_r   [NSQ+1];
  hws_pkg::sq_t        sq_l_nxt [NSQ];
  hws_pkg::sq_t        sq_r_nxt [NSQ];
  hws_pkg::vel_t       us_r     [NSQ+1];
  hws_pkg::vel_t       un_r     [NSQ+1];
  hws_pkg::face_case_t fc_r     [NSQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_l_r[0] <= '{rad: {1'b0, prod_l_nxt}, root: '0, rem: '0};
      sq_r_r[0] <= '{rad: {1'b0, prod_r_nxt}, root: '0, rem: '0};
      us_r[0]   <= in_vel_left;
      un_r[0]   <= in_vel_right;
      fc_r[0]   <= fc_nxt;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    assign sq_l_nxt[k] = hws_pkg::sq_step(sq_l_r[k]);
    assign sq_r_nxt[k] = hws_pkg::sq_step(sq_r_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_l_r[k+1] <= sq_l_nxt[k];
        sq_r_r[k+1] <= sq_r_nxt[k];
        us_r[k+1]   <= us_r[k];
        un_r[k+1]   <= un_r[k];
        fc_r[k+1]   <= fc_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // C1: widen, form half sums, quarter difference and single-side terms
  // --------------------------------------------------------------------------
  hws_pkg::wide_t us_w;
  hws_pkg::wide_t un_w;
  hws_pkg::wide_t cs_w;
  hws_pkg::wide_t cn_w;

  assign us_w = {{(hws_pkg::WIDE_W-hws_pkg::VEL_W){us_r[NSQ][hws_pkg::VEL_W-1]}}, us_r[NSQ]};
  assign un_w = {{(hws_pkg::WIDE_W-hws_pkg::VEL_W){un_r[NSQ][hws_pkg::VEL_W-1]}}, un_r[NSQ]};
  assign cs_w = {{(hws_pkg::WIDE_W-hws_pkg::ROOT_W){1'b0}}, sq_l_r[NSQ].root};
  assign cn_w = {{(hws_pkg::WIDE_W-hws_pkg::ROOT_W){1'b0}}, sq_r_r[NSQ].root};

  logic                c1_vld_r;
  hws_pkg::face_case_t c1_fc_r;
  hws_pkg::wide_t      c1_hs_r;    // floor((us + un) / 2)
  hws_pkg::wide_t      c1_dc_r;    // cs - cn
  hws_pkg::wide_t      c1_hc_r;    // floor((cs + cn) / 2)
  hws_pkg::wide_t      c1_qd_r;    // floor((us - un) / 4)
  hws_pkg::wide_t      c1_a_r;     // us - cs
  hws_pkg::wide_t      c1_c_r;     // un + cn
  hws_pkg::wide_t      c1_ldl_r;   // un - 2cn
  hws_pkg::wide_t      c1_rdr_r;   // us + 2cs

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
    end else if (adv) begin
      c1_vld_r <= sq_vld_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_fc_r  <= fc_r[NSQ];
      c1_hs_r  <= (us_w + un_w) >>> 1;
      c1_dc_r  <= cs_w - cn_w;
      c1_hc_r  <= (cs_w + cn_w) >>> 1;
      c1_qd_r  <= (us_w - un_w) >>> 2;
      c1_a_r   <= us_w - cs_w;
      c1_c_r   <= un_w + cn_w;
      c1_ldl_r <= un_w - (cn_w <<< 1);
      c1_rdr_r <= us_w + (cs_w <<< 1);
    end
  end

  // --------------------------------------------------------------------------
  // C2: star velocity and star celerity
  // --------------------------------------------------------------------------
  logic                c2_vld_r;
  hws_pkg::face_case_t c2_fc_r;
  hws_pkg::wide_t      c2_ustar_r;
  hws_pkg::wide_t      c2_dstar_r;
  hws_pkg::wide_t      c2_a_r;
  hws_pkg::wide_t      c2_c_r;
  hws_pkg::wide_t      c2_ldl_r;
  hws_pkg::wide_t      c2_rdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_vld_r <= 1'b0;
    end else if (adv) begin
      c2_vld_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_fc_r    <= c1_fc_r;
      c2_ustar_r <= c1_hs_r + c1_dc_r;
      c2_dstar_r <= c1_hc_r + c1_qd_r;
      c2_a_r     <= c1_a_r;
      c2_c_r     <= c1_c_r;
      c2_ldl_r   <= c1_ldl_r;
      c2_rdr_r   <= c1_rdr_r;
    end
  end

  // --------------------------------------------------------------------------
  // C3: Einfeldt bounds and case selection
  // --------------------------------------------------------------------------
  hws_pkg::wide_t b_w;
  hws_pkg::wide_t d_w;
  hws_pkg::wide_t sl_nxt;
  hws_pkg::wide_t sr_nxt;
  hws_pkg::wide_t ss_nxt;
  logic           upd_nxt;

  assign b_w = c2_ustar_r - c2_dstar_r;
  assign d_w = c2_ustar_r + c2_dstar_r;

  always_comb begin
    sl_nxt  = '0;
    sr_nxt  = '0;
    ss_nxt  = '0;
    upd_nxt = 1'b0;
    unique case (c2_fc_r)
      hws_pkg::FC_BOTH_WET: begin
        sl_nxt  = (c2_a_r < b_w) ? c2_a_r : b_w;
        sr_nxt  = (c2_c_r > d_w) ? c2_c_r : d_w;
        ss_nxt  = c2_ustar_r;
        upd_nxt = 1'b1;
      end
      hws_pkg::FC_LEFT_DRY: begin
        sl_nxt  = c2_ldl_r;
        sr_nxt  = c2_c_r;
        ss_nxt  = c2_ldl_r;
        upd_nxt = 1'b1;
      end
      hws_pkg::FC_RIGHT_DRY: begin
        // right speed taken as u + 2c
        sl_nxt  = c2_a_r;
        sr_nxt  = c2_rdr_r;
        ss_nxt  = c2_rdr_r;
        upd_nxt = 1'b1;
      end
      hws_pkg::FC_BOTH_DRY: begin
        upd_nxt = 1'b1;
      end
      hws_pkg::FC_NONE: begin
        upd_nxt = 1'b0;
      end
      default: begin
        upd_nxt = 1'b0;
      end
    endcase
  end

  logic           c3_vld_r;
  hws_pkg::wide_t c3_sl_r;
  hws_pkg::wide_t c3_sr_r;
  hws_pkg::wide_t c3_ss_r;
  logic           c3_upd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_vld_r <= 1'b0;
    end else if (adv) begin
      c3_vld_r <= c2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_sl_r  <= sl_nxt;
      c3_sr_r  <= sr_nxt;
      c3_ss_r  <= ss_nxt;
      c3_upd_r <= upd_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: saturate to 32 bits
  // --------------------------------------------------------------------------
  hws_pkg::vel_t out_sl_r;
  hws_pkg::vel_t out_sr_r;
  hws_pkg::vel_t out_ss_r;
  logic          out_upd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sl_r  <= hws_pkg::sat_vel(c3_sl_r);
      out_sr_r  <= hws_pkg::sat_vel(c3_sr_r);
      out_ss_r  <= hws_pkg::sat_vel(c3_ss_r);
      out_upd_r <= c3_upd_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_speed_left  = out_sl_r;
  assign out_speed_right = out_sr_r;
  assign out_speed_star  = out_ss_r;
  assign out_updated     = out_upd_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HWS_ASSERT(a_entry_follows_input,
              $past(rst_n) && $past(adv) |-> sq_vld_r[0] == $past(in_valid),
              "entry valid bit does not follow accepted input")
  `HWS_NEVER(a_sqrt_rem_bound,
             sq_vld_r[NSQ] && (sq_l_r[NSQ].rem > {sq_l_r[NSQ].root, 1'b0} ||
                               sq_r_r[NSQ].rem > {sq_r_r[NSQ].root, 1'b0}),
             "square root remainder exceeds twice the root")
  `HWS_NEVER(a_idle_speeds_zero,
             out_valid_r && !out_upd_r &&
             (out_sl_r != '0 || out_sr_r != '0 || out_ss_r != '0),
             "unmatched face carries nonzero speeds")

endmodule

`default_nettype wire
